// ===== rtl/core/bcc_pkg.sv =====
// shared types and constants of the button click classifier
package bcc_pkg;

  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned TIME_IN_W    = 32;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

  // reset values of the registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd250;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEB1     = 3'd1,
    PH_HELD     = 3'd2,
    PH_GAP      = 3'd3,
    PH_DEB2     = 3'd4,
    PH_WAIT_REL = 3'd5
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
  } cfg_t;

endpackage

// ===== rtl/core/bcc_cfg.sv =====
// configuration registers of the button click classifier
module bcc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcc_pkg::CFG_W-1:0]      cfg_wdata_i,
  output bcc_pkg::cfg_t                  cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:     cfg_d.debounce_ms     = cfg_wdata_i;
        CFG_LONG_PRESS:   cfg_d.long_press_ms   = cfg_wdata_i;
        CFG_DOUBLE_CLICK: cfg_d.double_click_ms = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DEBOUNCE_RST;
      cfg_q.long_press_ms   <= LONG_PRESS_RST;
      cfg_q.double_click_ms <= DOUBLE_CLICK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bcc_fsm.sv =====
// gesture state machine with edge time stamp and elapsed-time compares
module bcc_fsm #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   pin_level_i,
  input  logic [TIME_WIDTH-1:0]  time_now_i,
  input  bcc_pkg::cfg_t          cfg_i,
  output bcc_pkg::event_e        event_o
);
  import bcc_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  phase_e                phase_q, phase_d;
  logic [TIME_WIDTH-1:0] edge_time_q, edge_time_d;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [CMP_W-1:0]      elapsed_ext;
  logic                  pressed;
  logic                  deb_done, long_done, dbl_done;
  event_e                ev;

  // wrapping difference since the last edge
  assign elapsed     = time_now_i - edge_time_q;
  assign elapsed_ext = CMP_W'(elapsed);
  assign pressed     = ~pin_level_i;

  assign deb_done  = elapsed_ext >= CMP_W'(cfg_i.debounce_ms);
  assign long_done = elapsed_ext >= CMP_W'(cfg_i.long_press_ms);
  assign dbl_done  = elapsed_ext >= CMP_W'(cfg_i.double_click_ms);

  always_comb begin
    phase_d     = phase_q;
    edge_time_d = edge_time_q;
    ev          = EV_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (pressed) begin
          phase_d     = PH_DEB1;
          edge_time_d = time_now_i;
        end
      end
      PH_DEB1: begin
        if (deb_done) begin
          phase_d = pressed ? PH_HELD : PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          phase_d     = PH_GAP;
          edge_time_d = time_now_i;
        end else if (long_done) begin
          ev      = EV_LONG;
          phase_d = PH_WAIT_REL;
        end
      end
      PH_GAP: begin
        if (pressed) begin
          phase_d     = PH_DEB2;
          edge_time_d = time_now_i;
        end else if (dbl_done) begin
          ev      = EV_SINGLE;
          phase_d = PH_IDLE;
        end
      end
      PH_DEB2: begin
        if (deb_done) begin
          if (pressed) begin
            ev      = EV_DOUBLE;
            phase_d = PH_WAIT_REL;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_WAIT_REL: begin
        if (!pressed) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      edge_time_q <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      edge_time_q <= edge_time_d;
    end
  end

  assign event_o = ev;

  // state and edge stamp only move with a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(edge_time_q) && $stable(phase_q))
    else $error("fsm state changed without a word");

  // a double click only comes out of the second press debounce
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (ev == EV_DOUBLE) |-> phase_q == PH_DEB2)
    else $error("double click outside second press debounce");

  // long press and double click events are followed by waiting for release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && ((ev == EV_LONG) || (ev == EV_DOUBLE)) |=> phase_q == PH_WAIT_REL)
    else $error("press event not followed by wait for release");

endmodule

// ===== rtl/core/button_click_classifier.sv =====
// top level of the button click classifier: stream ports, input and result registers
// path: input register, then one subtract and compare into the state machine, then the result
// register that drives m_axis; throughput is one word per cycle while m_axis_tready is high
// the input register takes a new word whenever the result register is free or being drained
// reset (rst_ni low, asynchronous) clears both valid flags, the state machine to idle,
// the edge stamp to zero and the registers to 20, 1000 and 250 ms
module button_click_classifier #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bcc_pkg::CFG_W-1:0]         cfg_wdata_i,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bcc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] pin_level, [32:1] time_now
  // event stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [1:0] event_res
);
  import bcc_pkg::*;

  cfg_t                  cfg;
  logic                  in_valid_q;
  logic                  pin_q;
  logic [TIME_WIDTH-1:0] time_q;
  logic                  out_valid_q;
  event_e                event_q;
  event_e                event_c;
  logic                  advance;
  logic                  in_take;

  // input word moves on when the result register is empty or is being read
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload, time stamp fitted to the timer width
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q  <= s_axis_tdata[0];
      time_q <= TIME_WIDTH'(s_axis_tdata[TIME_IN_W:1]);
    end
  end

  bcc_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .pin_level_i (pin_q),
    .time_now_i  (time_q),
    .cfg_i       (cfg),
    .event_o     (event_c)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(event_q);

  // a held input word is never dropped while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input word lost during stall");

  // a pending result is not overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !advance)
    else $error("result overwritten while stalled");

endmodule

// ===== bench/tb.sv =====
// self-checking stream bench for the button click classifier
`timescale 1ns / 1ps

module tb;
  import bcc_pkg::*;

  // run guard, far above the slowest legal run
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // length of each long receiver hold-off
  localparam int unsigned LONG_HOLD    = 300;
  // index with no register behind it, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // one pin sample as it sits in tdata: pin in bit 0, time stamp above it
  typedef struct packed {
    logic [TIME_IN_W-1:0] stamp;
    logic                 pin;
  } sample_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [0] pin_level, [32:1] time_now
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;        // [1:0] event_res

  button_click_classifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // samples waiting to be offered, and events predicted for accepted samples
  sample_t samples_q[$];
  event_e  events_q[$];

  // shadow of the classifier: thresholds, gesture phase and last edge stamp
  cfg_t                 limits;
  phase_e               phase_q;
  logic [TIME_IN_W-1:0] edge_stamp;

  // running millisecond clock of the generated gestures
  logic [TIME_IN_W-1:0] clock_now;

  int unsigned samples_made = 0;
  int unsigned events_seen  = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_mark    = 400;

  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  int unsigned take_gap  = 0;
  int unsigned take_calm = 0;
  int unsigned hold_left = 0;
  event_e      want_ev;

  // next step of the gesture state machine for one accepted sample
  function automatic event_e classify(input sample_t smp);
    logic                 pressed;
    logic [TIME_IN_W-1:0] gone;
    event_e               ev;
    pressed = !smp.pin;
    gone    = smp.stamp - edge_stamp;  // wraps modulo 2^32
    ev      = EV_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (pressed) begin
          phase_q    = PH_DEB1;
          edge_stamp = smp.stamp;
        end
      end
      PH_DEB1: begin
        if (gone >= TIME_IN_W'(limits.debounce_ms)) begin
          if (pressed) phase_q = PH_HELD;
          else         phase_q = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          phase_q    = PH_GAP;
          edge_stamp = smp.stamp;
        end else if (gone >= TIME_IN_W'(limits.long_press_ms)) begin
          ev      = EV_LONG;
          phase_q = PH_WAIT_REL;
        end
      end
      PH_GAP: begin
        if (pressed) begin
          phase_q    = PH_DEB2;
          edge_stamp = smp.stamp;
        end else if (gone >= TIME_IN_W'(limits.double_click_ms)) begin
          ev      = EV_SINGLE;
          phase_q = PH_IDLE;
        end
      end
      PH_DEB2: begin
        if (gone >= TIME_IN_W'(limits.debounce_ms)) begin
          if (pressed) begin
            ev      = EV_DOUBLE;
            phase_q = PH_WAIT_REL;
          end else begin
            phase_q = PH_IDLE;
          end
        end
      end
      PH_WAIT_REL: begin
        if (!pressed) phase_q = PH_IDLE;
      end
      default: begin
        phase_q = PH_IDLE;
      end
    endcase
    return ev;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pace();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put(input logic pin, input logic [TIME_IN_W-1:0] at_ms);
    samples_q.push_back('{stamp: at_ms, pin: pin});
    samples_made++;
  endfunction

  // a random span that lands on either side of a threshold, sometimes on it
  function automatic int unsigned span_near(input logic [CFG_W-1:0] thr);
    int unsigned thr_ms;
    thr_ms = 32'(thr);
    if ($urandom_range(0, 3) == 0) return thr_ms;
    return $urandom_range(0, 2 * thr_ms + 3);
  endfunction

  // keep the pin at one level for a span, sampled at random steps
  function automatic void hold_level(input logic level, input int unsigned span);
    int unsigned done_ms;
    int unsigned stride;
    done_ms = 0;
    stride  = span / 4 + 1;
    do begin
      stride    = $urandom_range(1, span / 4 + 1);
      clock_now = clock_now + stride;
      done_ms   = done_ms + stride;
      put(level, clock_now);
    end while (done_ms < span);
  endfunction

  // press, release, maybe a second press, then a quiet tail
  function automatic void gesture();
    hold_level(1'b0, span_near($urandom_range(0, 1) ? limits.debounce_ms
                                                    : limits.long_press_ms));
    hold_level(1'b1, span_near(limits.double_click_ms));
    if ($urandom_range(0, 1)) begin
      hold_level(1'b0, span_near($urandom_range(0, 1) ? limits.debounce_ms
                                                      : limits.long_press_ms));
      hold_level(1'b1, span_near(limits.double_click_ms));
    end
    // lets a pending single click come out
    hold_level(1'b1, 32'(limits.double_click_ms) + 1);
  endfunction

  // random pin chatter, with jumps anywhere on the time line
  function automatic void noise();
    int unsigned burst;
    burst = $urandom_range(1, 12);
    repeat (burst) begin
      if ($urandom_range(0, 3) == 0) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(0, 40);
      put(1'($urandom_range(0, 1)), clock_now);
    end
  endfunction

  function automatic void make_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = samples_made + count;
    while (samples_made < stop_at) begin
      roll = $urandom_range(0, 99);
      // park the clock just below the wrap so the next gesture spans it
      if (roll < 5) clock_now = '1 - $urandom_range(0, 2 * 32'(limits.long_press_ms) + 50);
      if (roll < 85) gesture();
      else noise();
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_DEBOUNCE:     limits.debounce_ms     = val;
      CFG_LONG_PRESS:   limits.long_press_ms   = val;
      CFG_DOUBLE_CLICK: limits.double_click_ms = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                            input logic [CFG_W-1:0] dbl);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lng);
    write_reg(CFG_DOUBLE_CLICK, dbl);
  endtask

  // every sample gives exactly one event, so the block is idle once counts match
  task automatic settle();
    while (events_seen != samples_made) @(posedge clk_i);
  endtask

  // sample driver: takes the next word from the queue after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
      send_calm     <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      // word accepted at this edge: predict its event
      if (s_axis_tvalid) events_q.push_back(classify(sample_t'(s_axis_tdata[TIME_IN_W:0])));
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (samples_q.size() != 0) begin
        s_axis_tdata  <= IN_TDATA_W'(samples_q.pop_front());
        s_axis_tvalid <= 1'b1;
        // calm stretches send back to back
        if (send_calm != 0) begin
          send_calm <= send_calm - 1;
          send_gap  <= 0;
        end else begin
          send_gap <= pace();
          if ($urandom_range(0, 99) == 0) send_calm <= $urandom_range(50, 200);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // event monitor: checks each word and drives ready with stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_gap      <= 0;
      take_calm     <= 0;
      hold_left     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        events_seen = events_seen + 1;
        if (events_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected event word, expected none actual %0d",
                   $time, m_axis_tdata[1:0]);
        end else begin
          want_ev = events_q.pop_front();
          if (m_axis_tdata[1:0] !== want_ev) begin
            err_cnt++;
            $display("%0t: event_res mismatch, expected %0d actual %0d",
                     $time, want_ev, m_axis_tdata[1:0]);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (events_seen >= hold_mark) begin
        // long hold-off: sender keeps offering until the block backs up
        hold_mark      = hold_mark + 900;
        hold_left     <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap      <= take_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (take_calm != 0) begin
          take_calm <= take_calm - 1;
          take_gap  <= 0;
        end else begin
          take_gap <= pace();
          if ($urandom_range(0, 99) == 0) take_calm <= $urandom_range(50, 200);
        end
      end
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    limits     = '{DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST};
    phase_q    = PH_IDLE;
    edge_stamp = '0;
    clock_now  = 32'h100;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed walk at the reset thresholds 20 / 1000 / 250
    put(1'b1, 32'h0000_0000);  // idle, lowest stamp
    put(1'b1, 32'hFFFF_FFFF);  // idle, highest stamp
    put(1'b0, 32'd100);        // press edge
    put(1'b0, 32'd119);        // one short of debounce
    put(1'b0, 32'd120);        // debounce met, held
    put(1'b1, 32'd200);        // release edge
    put(1'b1, 32'd449);        // one short of double window
    put(1'b1, 32'd450);        // single click
    put(1'b0, 32'd1000);       // first press
    put(1'b0, 32'd1020);       // held
    put(1'b1, 32'd1100);       // release
    put(1'b0, 32'd1200);       // second press inside window
    put(1'b0, 32'd1219);       // second debounce not yet met
    put(1'b0, 32'd1220);       // double click
    put(1'b0, 32'd1300);       // still held after double
    put(1'b1, 32'd1310);       // release back to idle
    put(1'b0, 32'd2000);       // press
    put(1'b1, 32'd2020);       // bounce: released when debounce ends
    put(1'b0, 32'd3000);       // press
    put(1'b0, 32'd3020);       // held
    put(1'b0, 32'd3999);       // one short of long press
    put(1'b0, 32'd4000);       // long press
    put(1'b1, 32'd4010);       // release back to idle
    put(1'b0, 32'hFFFF_FFF0);  // press just below the wrap
    put(1'b0, 32'h0000_0004);  // debounce met across the wrap
    put(1'b1, 32'h0000_0010);  // release
    put(1'b0, 32'h0000_0020);  // second press
    put(1'b1, 32'h0000_0034);  // second press bounces off
    make_traffic(250);

    // every threshold zero: met on the very next sample
    settle();
    set_limits('0, '0, '0);
    make_traffic(200);

    // every threshold at its top
    settle();
    set_limits('1, '1, '1);
    make_traffic(150);

    // small random thresholds keep most gestures short
    repeat (5) begin
      settle();
      set_limits(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 120)),
                 CFG_W'($urandom_range(0, 60)));
      if ($urandom_range(0, 1)) write_reg(CFG_SPARE, CFG_W'($urandom()));
      make_traffic(220);
    end

    settle();
    write_reg(CFG_SPARE, '1);
    set_limits(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 3000)),
               CFG_W'($urandom_range(0, 600)));
    make_traffic(150);

    settle();
    repeat (4) @(posedge clk_i);
    if (events_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d events still expected", $time, events_q.size());
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_cfg.sv
rtl/core/bcc_fsm.sv
rtl/core/button_click_classifier.sv
bench/tb.sv
